FILE: rtl/core/ttuv_pkg.sv
package ttuv_pkg;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
  } in_t;

  typedef struct packed {
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic               degenerate;
    logic               last_copy;
  } out_t;

  // datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_DIFF   = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_ACC    = 4'd4;
  localparam logic [3:0] OP_SIGN   = 4'd5;
  localparam logic [3:0] OP_SHIFT  = 4'd6;
  localparam logic [3:0] OP_SQ     = 4'd7;
  localparam logic [3:0] OP_SQACC  = 4'd8;
  localparam logic [3:0] OP_SQINIT = 4'd9;
  localparam logic [3:0] OP_SQRT   = 4'd10;
  localparam logic [3:0] OP_DINIT  = 4'd11;
  localparam logic [3:0] OP_DSTEP  = 4'd12;
  localparam logic [3:0] OP_DDONE  = 4'd13;

  localparam int SqrtSteps = 25;
  localparam int DivSteps  = 15;
  localparam int MulSteps  = 8;
  localparam int Comps     = 3;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] idx;
    logic [1:0] slot;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic big;
  } stat_t;

endpackage

FILE: rtl/core/ttuv_dp.sv
module ttuv_dp (
  input  logic           clk,
  input  ttuv_pkg::in_t  in_data,
  input  ttuv_pkg::cmd_t cmd,
  output ttuv_pkg::stat_t stat,
  output ttuv_pkg::out_t out_data
);

  logic [15:0] held_pos [6];
  logic [15:0] held_tex [4];
  logic [15:0] p2 [3];
  logic [15:0] u2, v2;

  logic signed [16:0] e0 [3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] du0, dv0, du1, dv1;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic signed [34:0] acc [4];

  logic        neg [3];
  logic [34:0] mag [3];
  logic        det_zero, mzero;
  logic [49:0] sum;

  logic [49:0] sq_n;
  logic [25:0] sq_rem;
  logic [24:0] root;
  logic [27:0] rem_t, trial;

  logic [38:0] drem, dvs;
  logic [14:0] quo;
  logic [15:0] res [3];
  logic        degen;

  logic signed [34:0] tv [3];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == ttuv_pkg::OP_SQ) begin
      mul_a = {1'b0, mag[cmd.idx[1:0]][23:0]};
      mul_b = {1'b0, mag[cmd.idx[1:0]][23:0]};
    end else begin
      case (cmd.idx)
        3'd0: begin mul_a = 25'(du0); mul_b = 25'(dv1); end
        3'd1: begin mul_a = 25'(du1); mul_b = 25'(dv0); end
        3'd2: begin mul_a = 25'(dv1); mul_b = 25'(e0[0]); end
        3'd3: begin mul_a = 25'(dv0); mul_b = 25'(e1[0]); end
        3'd4: begin mul_a = 25'(dv1); mul_b = 25'(e0[1]); end
        3'd5: begin mul_a = 25'(dv0); mul_b = 25'(e1[1]); end
        3'd6: begin mul_a = 25'(dv1); mul_b = 25'(e0[2]); end
        default: begin mul_a = 25'(dv0); mul_b = 25'(e1[2]); end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv[i] = acc[i + 1][34] ? -acc[i + 1] : acc[i + 1];
    end
    rem_t = {sq_rem, sq_n[49:48]};
    trial = {1'b0, root, 2'b01};
  end

  assign stat.big = (|mag[0][34:24]) | (|mag[1][34:24]) | (|mag[2][34:24]);

  always_ff @(posedge clk) begin
    case (cmd.op)
      ttuv_pkg::OP_LOAD: begin
        if (cmd.slot == 2'd0) begin
          held_pos[0] <= in_data.pos_x;
          held_pos[1] <= in_data.pos_y;
          held_pos[2] <= in_data.pos_z;
          held_tex[0] <= in_data.tex_u;
          held_tex[1] <= in_data.tex_v;
        end else if (cmd.slot == 2'd1) begin
          held_pos[3] <= in_data.pos_x;
          held_pos[4] <= in_data.pos_y;
          held_pos[5] <= in_data.pos_z;
          held_tex[2] <= in_data.tex_u;
          held_tex[3] <= in_data.tex_v;
        end else begin
          p2[0] <= in_data.pos_x;
          p2[1] <= in_data.pos_y;
          p2[2] <= in_data.pos_z;
          u2    <= in_data.tex_u;
          v2    <= in_data.tex_v;
        end
      end
      ttuv_pkg::OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          e0[i] <= $signed({held_pos[3 + i][15], held_pos[3 + i]})
                 - $signed({held_pos[i][15], held_pos[i]});
          e1[i] <= $signed({p2[i][15], p2[i]})
                 - $signed({held_pos[i][15], held_pos[i]});
        end
        du0 <= $signed({1'b0, held_tex[2]}) - $signed({1'b0, held_tex[0]});
        dv0 <= $signed({1'b0, held_tex[3]}) - $signed({1'b0, held_tex[1]});
        du1 <= $signed({1'b0, u2}) - $signed({1'b0, held_tex[0]});
        dv1 <= $signed({1'b0, v2}) - $signed({1'b0, held_tex[1]});
      end
      ttuv_pkg::OP_MUL, ttuv_pkg::OP_SQ: begin
        prod <= mul_a * mul_b;
      end
      ttuv_pkg::OP_ACC: begin
        // even index starts a term, odd index subtracts the cross product
        if (!cmd.idx[0]) begin
          acc[cmd.idx[2:1]] <= prod[34:0];
        end else begin
          acc[cmd.idx[2:1]] <= acc[cmd.idx[2:1]] - prod[34:0];
        end
      end
      ttuv_pkg::OP_SIGN: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= acc[i + 1][34] ^ acc[0][34];
          mag[i] <= tv[i];
        end
        det_zero <= (acc[0] == '0);
        mzero    <= (acc[1] == '0) && (acc[2] == '0) && (acc[3] == '0);
        sum      <= '0;
      end
      ttuv_pkg::OP_SHIFT: begin
        if (stat.big) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end
      end
      ttuv_pkg::OP_SQACC: begin
        sum <= sum + {2'b00, prod[47:0]};
      end
      ttuv_pkg::OP_SQINIT: begin
        sq_n   <= sum;
        sq_rem <= '0;
        root   <= '0;
      end
      ttuv_pkg::OP_SQRT: begin
        sq_n <= sq_n << 2;
        if (rem_t >= trial) begin
          sq_rem <= 26'(rem_t - trial);
          root   <= {root[23:0], 1'b1};
        end else begin
          sq_rem <= rem_t[25:0];
          root   <= {root[23:0], 1'b0};
        end
      end
      ttuv_pkg::OP_DINIT: begin
        drem <= {1'b0, mag[cmd.idx[1:0]][23:0], 14'd0} + {15'd0, root[24:1]};
        dvs  <= {root, 14'd0};
        quo  <= '0;
      end
      ttuv_pkg::OP_DSTEP: begin
        if (drem >= dvs) begin
          drem <= drem - dvs;
          quo  <= {quo[13:0], 1'b1};
        end else begin
          quo  <= {quo[13:0], 1'b0};
        end
        dvs <= dvs >> 1;
      end
      ttuv_pkg::OP_DDONE: begin
        res[cmd.idx[1:0]] <= neg[cmd.idx[1:0]] ? -{1'b0, quo} : {1'b0, quo};
      end
      default: begin
      end
    endcase
  end

  assign degen = det_zero | mzero | (root == '0);

  always_comb begin
    out_data.tan_x      = degen ? '0 : res[0];
    out_data.tan_y      = degen ? '0 : res[1];
    out_data.tan_z      = degen ? '0 : res[2];
    out_data.degenerate = degen;
    out_data.last_copy  = cmd.last;
  end

endmodule

FILE: rtl/core/ttuv_ctrl.sv
module ttuv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ttuv_pkg::stat_t stat,
  output ttuv_pkg::cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIFF   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_ACC    = 4'd3;
  localparam logic [3:0] ST_SIGN   = 4'd4;
  localparam logic [3:0] ST_SHIFT  = 4'd5;
  localparam logic [3:0] ST_SQ     = 4'd6;
  localparam logic [3:0] ST_SQACC  = 4'd7;
  localparam logic [3:0] ST_SQINIT = 4'd8;
  localparam logic [3:0] ST_SQRT   = 4'd9;
  localparam logic [3:0] ST_DINIT  = 4'd10;
  localparam logic [3:0] ST_DSTEP  = 4'd11;
  localparam logic [3:0] ST_DDONE  = 4'd12;
  localparam logic [3:0] ST_EMIT   = 4'd13;

  logic [3:0] state;
  logic [4:0] cnt;
  logic [2:0] idx;
  logic [1:0] slot;
  logic [1:0] copy;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  always_comb begin
    cmd.op   = ttuv_pkg::OP_NOP;
    cmd.idx  = idx;
    cmd.slot = slot;
    cmd.last = (copy == 2'd2);
    case (state)
      ST_IDLE:   cmd.op = in_valid ? ttuv_pkg::OP_LOAD : ttuv_pkg::OP_NOP;
      ST_DIFF:   cmd.op = ttuv_pkg::OP_DIFF;
      ST_MUL:    cmd.op = ttuv_pkg::OP_MUL;
      ST_ACC:    cmd.op = ttuv_pkg::OP_ACC;
      ST_SIGN:   cmd.op = ttuv_pkg::OP_SIGN;
      ST_SHIFT:  cmd.op = ttuv_pkg::OP_SHIFT;
      ST_SQ:     cmd.op = ttuv_pkg::OP_SQ;
      ST_SQACC:  cmd.op = ttuv_pkg::OP_SQACC;
      ST_SQINIT: cmd.op = ttuv_pkg::OP_SQINIT;
      ST_SQRT:   cmd.op = ttuv_pkg::OP_SQRT;
      ST_DINIT:  cmd.op = ttuv_pkg::OP_DINIT;
      ST_DSTEP:  cmd.op = ttuv_pkg::OP_DSTEP;
      ST_DDONE:  cmd.op = ttuv_pkg::OP_DDONE;
      default:   cmd.op = ttuv_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
      slot  <= '0;
      copy  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (slot inside {2'd2, 2'd3}) begin
              slot  <= '0;
              idx   <= '0;
              state <= ST_DIFF;
            end else begin
              slot <= slot + 2'd1;
            end
          end
        end
        ST_DIFF: state <= ST_MUL;
        ST_MUL:  state <= ST_ACC;
        ST_ACC: begin
          if (idx == 3'(ttuv_pkg::MulSteps - 1)) begin
            idx   <= '0;
            state <= ST_SIGN;
          end else begin
            idx   <= idx + 3'd1;
            state <= ST_MUL;
          end
        end
        ST_SIGN: state <= ST_SHIFT;
        ST_SHIFT: begin
          if (!stat.big) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_SQACC;
        ST_SQACC: begin
          if (idx == 3'(ttuv_pkg::Comps - 1)) begin
            idx   <= '0;
            state <= ST_SQINIT;
          end else begin
            idx   <= idx + 3'd1;
            state <= ST_SQ;
          end
        end
        ST_SQINIT: begin
          cnt   <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt == 5'(ttuv_pkg::SqrtSteps - 1)) begin
            state <= ST_DINIT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DINIT: begin
          cnt   <= '0;
          state <= ST_DSTEP;
        end
        ST_DSTEP: begin
          if (cnt == 5'(ttuv_pkg::DivSteps - 1)) begin
            state <= ST_DDONE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DDONE: begin
          if (idx == 3'(ttuv_pkg::Comps - 1)) begin
            copy  <= '0;
            state <= ST_EMIT;
          end else begin
            idx   <= idx + 3'd1;
            state <= ST_DINIT;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            if (copy == 2'd2) begin
              copy  <= '0;
              state <= ST_IDLE;
            end else begin
              copy <= copy + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/triangle_tangent_from_uv.sv
// triangle tangent from texture-coordinate deltas
// input channel: one vertex per beat (position q7.8, uv q0.16) in triangle
// order, handshake in_valid / in_stall. output channel: one tangent per beat
// (q1.14 unit vector, degenerate flag, last_copy), out_valid / out_stall.
// the first two vertices of a triangle are stored and give no result. the
// third vertex starts the triangle's computation: edge and uv differences,
// eight products on one shared 25x25 multiplier, a range-reduction shift,
// three squares, a bit-serial square root and three restoring divides.
// out_valid rises once the third divide is done, the wait after the third
// vertex varying only with the shift, and with no stalls the three copies
// follow on consecutive beats. most of a triangle's time goes to the square
// root and the divider loop.
// in_stall stays high from the third vertex until the last copy
// has been taken; while the receiver stalls, the current copy is held.
// reset returns to the first vertex slot with no result pending.
module triangle_tangent_from_uv (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ttuv_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ttuv_pkg::out_t out_data
);

  ttuv_pkg::cmd_t  cmd;
  ttuv_pkg::stat_t stat;

  ttuv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttuv_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

  // no vertex is taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during result delivery");

  // after the last copy leaves, the block goes back to taking vertices
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last_copy |=> !out_valid && !in_stall)
    else $error("result continued after last copy");

  // a degenerate triangle carries a zero tangent
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.tan_x == '0 && out_data.tan_y == '0 && out_data.tan_z == '0)
    else $error("degenerate result with nonzero tangent");

endmodule

FILE: verif/triangle_tangent_from_uv_test.sv
module triangle_tangent_from_uv_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandTris = 33;
  localparam int LongHold = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ttuv_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ttuv_pkg::out_t out_data;

  triangle_tangent_from_uv dut (.*);

  always #4 clk = ~clk;

  // tangent predictor state
  logic [15:0] pos_hold [6];
  logic [15:0] uv_hold [4];
  logic [1:0] vtx_slot;
  ttuv_pkg::out_t tangent_q [$];

  int errors = 0;
  int beats_out = 0;
  int tris_seen = 0;
  int degen_seen = 0;
  int take_gap = 0;
  int phase = 0;
  bit stim_done = 1'b0;
  longint cycles = 0;

  // directed vertices, with expected tangent where it is obvious
  typedef struct {
    ttuv_pkg::in_t v;
    bit known;
    ttuv_pkg::out_t want;
  } row_t;
  row_t dir_rows [$];

  function automatic logic [63:0] root_of(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic predict_tangent(input ttuv_pkg::in_t v);
    longint p0 [3], p1 [3], p2 [3], t [3];
    longint du0, dv0, du1, dv1, det;
    logic [63:0] mag [3], m, sum, len, q;
    logic [15:0] res [3];
    bit neg [3], degen;
    int s;
    ttuv_pkg::out_t o;
    if (vtx_slot < 2) begin
      pos_hold[vtx_slot*3+0] = v.pos_x;
      pos_hold[vtx_slot*3+1] = v.pos_y;
      pos_hold[vtx_slot*3+2] = v.pos_z;
      uv_hold[vtx_slot*2+0] = v.tex_u;
      uv_hold[vtx_slot*2+1] = v.tex_v;
      vtx_slot = vtx_slot + 2'd1;
      return;
    end
    vtx_slot = 0;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'($signed(pos_hold[i]));
      p1[i] = longint'($signed(pos_hold[3+i]));
    end
    p2[0] = longint'(v.pos_x);
    p2[1] = longint'(v.pos_y);
    p2[2] = longint'(v.pos_z);
    du0 = longint'(uv_hold[2]) - longint'(uv_hold[0]);
    dv0 = longint'(uv_hold[3]) - longint'(uv_hold[1]);
    du1 = longint'(v.tex_u) - longint'(uv_hold[0]);
    dv1 = longint'(v.tex_v) - longint'(uv_hold[1]);
    det = du0 * dv1 - du1 * dv0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = dv1 * (p1[i] - p0[i]) - dv0 * (p2[i] - p0[i]);
      if (det < 0) t[i] = -t[i];
      neg[i] = t[i] < 0;
      mag[i] = neg[i] ? -t[i] : t[i];
      if (mag[i] > m) m = mag[i];
      res[i] = '0;
    end
    degen = (det == 0) || (m == 0);
    if (!degen) begin
      s = 0;
      while ((m >> s) >= 64'h100_0000) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> s;
        sum += mag[i] * mag[i];
      end
      len = root_of(sum);
      if (len == 0) begin
        degen = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          q = ((mag[i] << 14) + (len >> 1)) / len;
          res[i] = neg[i] ? 16'(17'h10000 - q) : q[15:0];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      o.tan_x = res[0];
      o.tan_y = res[1];
      o.tan_z = res[2];
      o.degenerate = degen;
      o.last_copy = (k == 2);
      tangent_q = {tangent_q, o};
    end
  endtask

  function automatic ttuv_pkg::in_t vert(int x, int y, int z, int u, int v);
    ttuv_pkg::in_t r;
    r.pos_x = 16'(x);
    r.pos_y = 16'(y);
    r.pos_z = 16'(z);
    r.tex_u = 16'(u);
    r.tex_v = 16'(v);
    return r;
  endfunction

  function automatic ttuv_pkg::in_t rand_vert();
    ttuv_pkg::in_t r;
    r = {$urandom, $urandom, 16'($urandom)};
    // some small-range vertices so lengths stay modest
    if ($urandom_range(3) == 0) begin
      r.pos_x = 16'($signed($urandom_range(64)) - 32);
      r.pos_y = 16'($signed($urandom_range(64)) - 32);
      r.pos_z = 16'($signed($urandom_range(64)) - 32);
    end
    return r;
  endfunction

  task automatic add_row(ttuv_pkg::in_t v, bit known = 0, ttuv_pkg::out_t want = '0);
    row_t r;
    r.v = v;
    r.known = known;
    r.want = want;
    dir_rows = {dir_rows, r};
  endtask

  ttuv_pkg::out_t zero_degen;

  // stimulus
  int send_idle = 21;
  int take_idle = 52;

  // valid stays high from one beat to the next unless an idle gap is drawn
  task automatic send_vertex(input ttuv_pkg::in_t v);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (in_stall);
    predict_tangent(v);
  endtask

  initial begin
    row_t r;
    ttuv_pkg::out_t exp_beat;
    zero_degen = '0;
    zero_degen.degenerate = 1'b1;
    vtx_slot = 0;
    // all-equal uv: zero determinant
    add_row(vert(0, 0, 0, 0, 0));
    add_row(vert(32767, -32768, 32767, 0, 0));
    add_row(vert(-32768, 32767, -32768, 0, 0), 1, zero_degen);
    // coincident positions: zero-length tangent
    add_row(vert(100, 100, 100, 0, 0));
    add_row(vert(100, 100, 100, 65535, 0));
    add_row(vert(100, 100, 100, 0, 65535), 1, zero_degen);
    // extremes of every field, then one-step uv deltas; positive and negative determinant
    add_row(vert(-32768, -32768, -32768, 0, 0));
    add_row(vert(32767, 32767, 32767, 65535, 0));
    add_row(vert(-32768, 32767, -32768, 0, 65535));
    add_row(vert(32767, 0, -32768, 65535, 65535));
    add_row(vert(-32768, 0, 32767, 0, 65535));
    add_row(vert(0, -32768, 0, 65535, 0));
    add_row(vert(0, 0, 0, 0, 0));
    add_row(vert(256, 0, 0, 1, 0));
    add_row(vert(0, 256, 0, 0, 1));
    add_row(vert(0, 0, 0, 32768, 32768));
    add_row(vert(0, 0, -256, 32769, 32768));
    add_row(vert(0, 0, 256, 32768, 32767));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_vertex(r.v);
      // typed expectations stand in for the predicted beats
      if (r.known) begin
        for (int k = 0; k < 3; k++) begin
          exp_beat = r.want;
          exp_beat.last_copy = (k == 2);
          tangent_q[tangent_q.size() - 3 + k] = exp_beat;
        end
      end
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 52 : 0;
      take_idle = (ph == 0) ? 52 : (ph == 1) ? 21 : 0;
      phase = ph;
      for (int t = 0; t < RandTris / 3; t++) begin
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
          // third vertex repeats the first uv: zero determinant
          ttuv_pkg::in_t a, b;
          a = rand_vert();
          send_vertex(a);
          send_vertex(rand_vert());
          b = rand_vert();
          b.tex_u = a.tex_u;
          b.tex_v = a.tex_v;
          send_vertex(b);
        end else begin
          send_vertex(rand_vert());
          send_vertex(rand_vert());
          send_vertex(rand_vert());
        end
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls and one long hold-off
  int hold_cnt = 0;
  bit held_once = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (phase == 1 && !held_once) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
      if (hold_cnt == LongHold - 1) held_once <= 1'b1;
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < take_idle) begin
      take_gap <= $urandom_range(5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check
  always @(posedge clk) begin
    ttuv_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (tangent_q.size() == 0) begin
        errors++;
        $error("unexpected tangent beat %h", out_data);
      end else begin
        want = tangent_q.pop_front();
        if (want.last_copy) tris_seen++;
        if (want.last_copy && want.degenerate) degen_seen++;
        if (out_data.tan_x !== want.tan_x) begin
          errors++;
          $error("tan_x expected %0d got %0d", want.tan_x, out_data.tan_x);
        end
        if (out_data.tan_y !== want.tan_y) begin
          errors++;
          $error("tan_y expected %0d got %0d", want.tan_y, out_data.tan_y);
        end
        if (out_data.tan_z !== want.tan_z) begin
          errors++;
          $error("tan_z expected %0d got %0d", want.tan_z, out_data.tan_z);
        end
        if (out_data.degenerate !== want.degenerate) begin
          errors++;
          $error("degenerate expected %0b got %0b", want.degenerate, out_data.degenerate);
        end
        if (out_data.last_copy !== want.last_copy) begin
          errors++;
          $error("last_copy expected %0b got %0b", want.last_copy, out_data.last_copy);
        end
      end
    end
  end

  initial begin
    while (!(stim_done && tangent_q.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      repeat (150) @(posedge clk);
      $display("%0d triangles checked (%0d degenerate), %0d tangent beats",
               tris_seen, degen_seen, beats_out);
      $display("edge-case rows, random triangles under idling on both sides, one long hold-off");
      if (errors == 0 && tangent_q.size() == 0)
        $display("[ OK ] regression clean");
      else
        $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

FILE: triangle_tangent_from_uv.f
rtl/core/ttuv_pkg.sv
rtl/core/ttuv_dp.sv
rtl/core/ttuv_ctrl.sv
rtl/core/triangle_tangent_from_uv.sv
verif/triangle_tangent_from_uv_test.sv
